// File: rtl/core/uart_transceiver_core_defines.svh
// ----------------------------------------------------------------------------
// uart transceiver assertion macros
// shared property wrappers for the core and its units
// ----------------------------------------------------------------------------
`ifndef UART_TRANSCEIVER_CORE_DEFINES_SVH
`define UART_TRANSCEIVER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked on every rising edge out of reset
`define UTXC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("uart transceiver: implication check failed");

// next-cycle implication
`define UTXC_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("uart transceiver: next-cycle check failed");

`else

`define UTXC_ASSERT_IMP(label, clk, rst, ante, cons)
`define UTXC_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

// File: rtl/core/utx_pkg.sv
// ----------------------------------------------------------------------------
// utx_pkg
// item types, register indexes and frame settings for the uart transceiver
// ----------------------------------------------------------------------------
package utx_pkg;

   // register widths
   localparam int BIT_PERIOD_W  = 16;
   localparam int DATA_BITS_W   = 4;
   localparam int PARITY_MODE_W = 2;
   localparam int STOP_BITS_W   = 2;
   localparam int CSR_DATA_W    = 16;
   localparam int CSR_INDEX_W   = 2;
   localparam int BYTE_W        = 8;
   localparam int COUNT_W       = 4;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_BIT_PERIOD  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DATA_BITS   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PARITY_MODE = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_STOP_BITS   = 2'd3;

   // parity mode codes
   localparam logic [PARITY_MODE_W-1:0] PARITY_NONE = 2'd0;
   localparam logic [PARITY_MODE_W-1:0] PARITY_EVEN = 2'd1;
   localparam logic [PARITY_MODE_W-1:0] PARITY_ODD  = 2'd2;

   // register reset values
   localparam logic [BIT_PERIOD_W-1:0]  BIT_PERIOD_RST  = 16'd138;
   localparam logic [DATA_BITS_W-1:0]   DATA_BITS_RST   = 4'd8;
   localparam logic [PARITY_MODE_W-1:0] PARITY_MODE_RST = PARITY_NONE;
   localparam logic [STOP_BITS_W-1:0]   STOP_BITS_RST   = 2'd1;

   // input item
   typedef struct packed {
      logic              tx_start;
      logic [BYTE_W-1:0] tx_data;
      logic              rx_pin;
   } req_item_type;

   // result item
   typedef struct packed {
      logic              tx_line;
      logic              tx_busy;
      logic              rx_valid;
      logic [BYTE_W-1:0] rx_data;
   } rsp_item_type;

   // effective frame settings shared by both units
   typedef struct packed {
      logic [COUNT_W-1:0] nbits;
      logic               parity_on;
      logic               parity_odd;
      logic               stop_two;
   } frame_cfg_type;

endpackage

// File: rtl/core/utx_tx.sv
// ----------------------------------------------------------------------------
// utx_tx
// transmit sequencer: start, data lsb first, optional parity, stop bits
// ----------------------------------------------------------------------------
module utx_tx #(
   parameter int TIMER_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic                          tx_start,
   input  logic [utx_pkg::BYTE_W-1:0]    tx_data,
   input  logic [TIMER_BITS-1:0]         period,
   input  utx_pkg::frame_cfg_type        fcfg,
   output logic                          tx_line,
   output logic                          tx_busy
);
   import utx_pkg::*;

   localparam logic [2:0] TXP_IDLE   = 3'd0;
   localparam logic [2:0] TXP_START  = 3'd1;
   localparam logic [2:0] TXP_DATA   = 3'd2;
   localparam logic [2:0] TXP_PARITY = 3'd3;
   localparam logic [2:0] TXP_STOP   = 3'd4;

   logic [2:0]            phase_ff,  phase_in;
   logic [TIMER_BITS-1:0] timer_ff,  timer_in;
   logic [COUNT_W-1:0]    count_ff,  count_in;
   logic [BYTE_W-1:0]     shift_ff,  shift_in;
   logic                  parity_ff, parity_in;

   logic [TIMER_BITS-1:0] timer_inc;
   logic [COUNT_W-1:0]    count_inc;
   logic [COUNT_W-1:0]    stop_count;
   logic [BYTE_W-1:0]     masked;

   assign timer_inc  = timer_ff + 1'b1;
   assign count_inc  = count_ff + 1'b1;
   assign stop_count = fcfg.stop_two ? COUNT_W'(2) : COUNT_W'(1);

   // keep only the low nbits data bits
   always_comb begin
      for (int i = 0; i < BYTE_W; i++) begin
         masked[i] = tx_data[i] & (COUNT_W'(i) < fcfg.nbits);
      end
   end

   // next state for one tick
   always_comb begin
      phase_in  = phase_ff;
      timer_in  = timer_ff;
      count_in  = count_ff;
      shift_in  = shift_ff;
      parity_in = parity_ff;
      if (phase_ff == TXP_IDLE) begin
         if (tx_start) begin
            shift_in  = masked;
            parity_in = (^masked) ^ fcfg.parity_odd;
            phase_in  = TXP_START;
            timer_in  = '0;
            count_in  = '0;
         end
      end else if (timer_inc < period) begin
         timer_in = timer_inc;
      end else begin
         timer_in = '0;
         unique case (phase_ff)
            TXP_START: begin
               phase_in = TXP_DATA;
               count_in = '0;
            end
            TXP_DATA: begin
               count_in = count_inc;
               shift_in = shift_ff >> 1;
               if (count_inc >= fcfg.nbits) begin
                  count_in = '0;
                  phase_in = fcfg.parity_on ? TXP_PARITY : TXP_STOP;
               end
            end
            TXP_PARITY: begin
               phase_in = TXP_STOP;
               count_in = '0;
            end
            default: begin
               count_in = count_inc;
               if (count_inc >= stop_count) begin
                  count_in = '0;
                  phase_in = TXP_IDLE;
               end
            end
         endcase
      end
   end

   // line level from the state after this tick
   always_comb begin
      unique case (phase_in)
         TXP_START:  tx_line = 1'b0;
         TXP_DATA:   tx_line = shift_in[0];
         TXP_PARITY: tx_line = parity_in;
         default:    tx_line = 1'b1;
      endcase
   end

   assign tx_busy = (phase_in != TXP_IDLE);

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= TXP_IDLE;
         timer_ff  <= '0;
         count_ff  <= '0;
         shift_ff  <= '0;
         parity_ff <= 1'b0;
      end else if (step) begin
         phase_ff  <= phase_in;
         timer_ff  <= timer_in;
         count_ff  <= count_in;
         shift_ff  <= shift_in;
         parity_ff <= parity_in;
      end
   end

`include "uart_transceiver_core_defines.svh"

   `UTXC_ASSERT_IMP(a_tx_idle_timer_clear, clock, reset, phase_ff == TXP_IDLE, timer_ff == '0)
   `UTXC_ASSERT_IMP(a_tx_count_range, clock, reset, 1'b1, count_ff < COUNT_W'(BYTE_W))

endmodule

// File: rtl/core/utx_rx.sv
// ----------------------------------------------------------------------------
// utx_rx
// receive sampler: edge detect, mid-bit sampling, byte assembly
// ----------------------------------------------------------------------------
module utx_rx #(
   parameter int TIMER_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic                          rx_pin,
   input  logic [TIMER_BITS-1:0]         period,
   input  utx_pkg::frame_cfg_type        fcfg,
   output logic                          rx_valid,
   output logic [utx_pkg::BYTE_W-1:0]    rx_data
);
   import utx_pkg::*;

   localparam logic [1:0] RXP_WAIT_HIGH = 2'd0;
   localparam logic [1:0] RXP_WAIT_EDGE = 2'd1;
   localparam logic [1:0] RXP_FIRST     = 2'd2;
   localparam logic [1:0] RXP_DATA      = 2'd3;

   logic [1:0]            phase_ff, phase_in;
   logic [TIMER_BITS:0]   timer_ff, timer_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [BYTE_W-1:0]     shift_ff, shift_in;

   logic [TIMER_BITS:0]   timer_inc;
   logic [TIMER_BITS:0]   first_limit;
   logic [COUNT_W-1:0]    count_inc;
   logic [BYTE_W-1:0]     shift_new;
   logic                  sample;

   assign timer_inc   = timer_ff + 1'b1;
   assign first_limit = {1'b0, period} + {2'b00, period[TIMER_BITS-1:1]};
   assign count_inc   = count_ff + 1'b1;
   assign shift_new   = shift_ff | (BYTE_W'(rx_pin) << count_ff[2:0]);

   // sample point: one and a half periods for bit 0, one period after
   always_comb begin
      unique case (phase_ff)
         RXP_FIRST: sample = (timer_inc >= first_limit);
         RXP_DATA:  sample = (timer_inc >= {1'b0, period});
         default:   sample = 1'b0;
      endcase
   end

   // next state for one tick
   always_comb begin
      phase_in = phase_ff;
      timer_in = timer_ff;
      count_in = count_ff;
      shift_in = shift_ff;
      rx_valid = 1'b0;
      rx_data  = '0;
      unique case (phase_ff)
         RXP_WAIT_HIGH: begin
            if (rx_pin) begin
               phase_in = RXP_WAIT_EDGE;
            end
         end
         RXP_WAIT_EDGE: begin
            if (!rx_pin) begin
               phase_in = RXP_FIRST;
               timer_in = '0;
               count_in = '0;
               shift_in = '0;
            end
         end
         default: begin
            if (!sample) begin
               timer_in = timer_inc;
            end else begin
               timer_in = '0;
               phase_in = RXP_DATA;
               shift_in = shift_new;
               count_in = count_inc;
               if (count_inc >= fcfg.nbits) begin
                  rx_valid = 1'b1;
                  rx_data  = shift_new;
                  shift_in = '0;
                  count_in = '0;
                  phase_in = RXP_WAIT_HIGH;
               end
            end
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= RXP_WAIT_HIGH;
         timer_ff <= '0;
         count_ff <= '0;
         shift_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         timer_ff <= timer_in;
         count_ff <= count_in;
         shift_ff <= shift_in;
      end
   end

`include "uart_transceiver_core_defines.svh"

   `UTXC_ASSERT_IMP(a_rx_count_range, clock, reset, 1'b1, count_ff < COUNT_W'(BYTE_W))

endmodule

// File: rtl/core/uart_transceiver_core.sv
// ----------------------------------------------------------------------------
// uart_transceiver_core
// one uart transmitter and one receiver stepped by one input item per tick
// ----------------------------------------------------------------------------
// Each accepted input item is one tick of the bit clock and yields exactly one
// result item, registered in the result register or, while it is held, in its
// skid stage. The core takes one item every cycle unless req_stall is high;
// req_stall rises only when the result register and its skid stage are both full,
// so the consumer alone sets throughput. Csr settings act on the next accepted item.
module uart_transceiver_core #(
   parameter int TIMER_BITS    = 16,
   parameter int MAX_DATA_BITS = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  utx_pkg::req_item_type              req_item,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output utx_pkg::rsp_item_type              rsp_item,
   input  logic                               csr_write,
   input  logic [utx_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [utx_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import utx_pkg::*;

   logic [BIT_PERIOD_W-1:0]  bit_period_ff;
   logic [DATA_BITS_W-1:0]   data_bits_ff;
   logic [PARITY_MODE_W-1:0] parity_mode_ff;
   logic [STOP_BITS_W-1:0]   stop_bits_ff;

   logic [TIMER_BITS-1:0]    period_raw;
   logic [TIMER_BITS-1:0]    period;
   frame_cfg_type            fcfg;

   logic                     accept;
   rsp_item_type             result;
   logic                     out_valid_ff;
   rsp_item_type             out_ff;
   logic                     skid_valid_ff;
   rsp_item_type             skid_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bit_period_ff  <= BIT_PERIOD_RST;
         data_bits_ff   <= DATA_BITS_RST;
         parity_mode_ff <= PARITY_MODE_RST;
         stop_bits_ff   <= STOP_BITS_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_BIT_PERIOD:  bit_period_ff  <= csr_wdata[BIT_PERIOD_W-1:0];
            CSR_DATA_BITS:   data_bits_ff   <= csr_wdata[DATA_BITS_W-1:0];
            CSR_PARITY_MODE: parity_mode_ff <= csr_wdata[PARITY_MODE_W-1:0];
            CSR_STOP_BITS:   stop_bits_ff   <= csr_wdata[STOP_BITS_W-1:0];
            default: ;
         endcase
      end
   end

   // bit period saturated to the timer range
   generate
      if (TIMER_BITS >= BIT_PERIOD_W) begin : g_period_wide
         assign period_raw = TIMER_BITS'(bit_period_ff);
      end else begin : g_period_sat
         assign period_raw = (|bit_period_ff[BIT_PERIOD_W-1:TIMER_BITS]) ? '1
                           : bit_period_ff[TIMER_BITS-1:0];
      end
   endgenerate

   assign period = (period_raw == '0) ? TIMER_BITS'(1) : period_raw;

   // frame settings clamped to their legal ranges
   always_comb begin
      if (data_bits_ff == '0) begin
         fcfg.nbits = COUNT_W'(1);
      end else if (data_bits_ff > DATA_BITS_W'(MAX_DATA_BITS)) begin
         fcfg.nbits = COUNT_W'(MAX_DATA_BITS);
      end else begin
         fcfg.nbits = data_bits_ff;
      end
      fcfg.parity_on  = (parity_mode_ff == PARITY_EVEN) || (parity_mode_ff == PARITY_ODD);
      fcfg.parity_odd = (parity_mode_ff == PARITY_ODD);
      fcfg.stop_two   = stop_bits_ff[1];
   end

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;

   utx_tx #(
      .TIMER_BITS (TIMER_BITS)
   ) u_tx (
      .clock    (clock),
      .reset    (reset),
      .step     (accept),
      .tx_start (req_item.tx_start),
      .tx_data  (req_item.tx_data),
      .period   (period),
      .fcfg     (fcfg),
      .tx_line  (result.tx_line),
      .tx_busy  (result.tx_busy)
   );

   utx_rx #(
      .TIMER_BITS (TIMER_BITS)
   ) u_rx (
      .clock    (clock),
      .reset    (reset),
      .step     (accept),
      .rx_pin   (req_item.rx_pin),
      .period   (period),
      .fcfg     (fcfg),
      .rx_valid (result.rx_valid),
      .rx_data  (result.rx_data)
   );

   // result register with skid stage
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || !rsp_stall) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= accept;
         end
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   // result payloads
   always_ff @(posedge clock) begin
      if (!out_valid_ff || !rsp_stall) begin
         if (skid_valid_ff) begin
            out_ff <= skid_ff;
         end else if (accept) begin
            out_ff <= result;
         end
      end else if (accept) begin
         skid_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_ff;

`include "uart_transceiver_core_defines.svh"

   `UTXC_ASSERT_IMP(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff)
   `UTXC_ASSERT_NXT(a_no_accept_when_full, clock, reset, skid_valid_ff && rsp_stall, skid_valid_ff)

endmodule

// File: dv/uart_frame_checker.sv
// ----------------------------------------------------------------------------
// uart_frame_checker
// watches the item channels of the uart transceiver core, predicts every
// result item from its own copy of the transmitter, receiver and frame
// settings, and compares each field with what the core returns
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uart_frame_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  utx_pkg::req_item_type           req_item,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  utx_pkg::rsp_item_type           rsp_item,
   input  logic                            csr_write,
   input  logic [utx_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [utx_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                              mismatch_count,
   output int                              pending_ticks
);
   import utx_pkg::*;

   typedef enum logic [2:0] {TX_IDLE, TX_START, TX_DATA, TX_PARITY, TX_STOP} tx_phase_type;
   typedef enum logic [1:0] {RX_WAIT_HIGH, RX_WAIT_EDGE, RX_FIRST, RX_DATA} rx_phase_type;

   // frame settings as last written
   logic [BIT_PERIOD_W-1:0]  cfg_period;
   logic [DATA_BITS_W-1:0]   cfg_dbits;
   logic [PARITY_MODE_W-1:0] cfg_parity;
   logic [STOP_BITS_W-1:0]   cfg_stop;

   // transmitter and receiver state
   tx_phase_type      tx_phase;
   int unsigned       tx_timer;
   logic [3:0]        tx_count;
   logic [BYTE_W-1:0] tx_shift;
   logic              tx_parity;
   rx_phase_type      rx_phase;
   int unsigned       rx_timer;
   logic [3:0]        rx_count;
   logic [BYTE_W-1:0] rx_shift;

   rsp_item_type line_state_q[$];
   rsp_item_type want;
   int           mismatch_total;

   // one tick of both units, returns the line state seen after it
   function automatic rsp_item_type uart_tick(req_item_type it);
      int unsigned       period;
      logic [3:0]        nbits;
      logic [1:0]        nstop;
      logic              par_on;
      logic [8:0]        mask;
      logic              take_bit;
      logic              got_word;
      logic [BYTE_W-1:0] rx_word;
      rsp_item_type      res;
      period   = (cfg_period == 0) ? 1 : cfg_period;
      nbits    = (cfg_dbits == 0) ? 4'd1 : (cfg_dbits > 4'd8) ? 4'd8 : cfg_dbits;
      nstop    = (cfg_stop == 0) ? 2'd1 : (cfg_stop == 2'd3) ? 2'd2 : cfg_stop;
      par_on   = (cfg_parity == PARITY_EVEN) || (cfg_parity == PARITY_ODD);
      take_bit = 1'b0;
      got_word = 1'b0;
      rx_word  = '0;

      // transmitter: a request is taken only while idle
      if (tx_phase == TX_IDLE) begin
         if (it.tx_start) begin
            mask      = (9'd1 << nbits) - 9'd1;
            tx_shift  = it.tx_data & mask[7:0];
            tx_parity = (^tx_shift) ^ (cfg_parity == PARITY_ODD);
            tx_phase  = TX_START;
            tx_timer  = 0;
            tx_count  = '0;
         end
      end else begin
         tx_timer++;
         if (tx_timer >= period) begin
            tx_timer = 0;
            case (tx_phase)
               TX_START: begin
                  tx_phase = TX_DATA;
                  tx_count = '0;
               end
               TX_DATA: begin
                  tx_count = tx_count + 4'd1;
                  tx_shift = tx_shift >> 1;
                  if (tx_count >= nbits) begin
                     tx_count = '0;
                     tx_phase = par_on ? TX_PARITY : TX_STOP;
                  end
               end
               TX_PARITY: begin
                  tx_phase = TX_STOP;
                  tx_count = '0;
               end
               default: begin
                  tx_count = tx_count + 4'd1;
                  if (tx_count >= nstop) begin
                     tx_count = '0;
                     tx_phase = TX_IDLE;
                  end
               end
            endcase
         end
      end

      // receiver: arm on high, start on falling edge, sample mid-bit
      case (rx_phase)
         RX_WAIT_HIGH: begin
            if (it.rx_pin) rx_phase = RX_WAIT_EDGE;
         end
         RX_WAIT_EDGE: begin
            if (!it.rx_pin) begin
               rx_phase = RX_FIRST;
               rx_timer = 0;
               rx_count = '0;
               rx_shift = '0;
            end
         end
         RX_FIRST: begin
            rx_timer++;
            take_bit = rx_timer >= period + (period >> 1);
         end
         default: begin
            rx_timer++;
            take_bit = rx_timer >= period;
         end
      endcase
      if (take_bit) begin
         rx_timer = 0;
         rx_phase = RX_DATA;
         rx_shift = rx_shift | (8'(it.rx_pin) << rx_count[2:0]);
         rx_count = rx_count + 4'd1;
         if (rx_count >= nbits) begin
            got_word = 1'b1;
            rx_word  = rx_shift;
            rx_shift = '0;
            rx_count = '0;
            rx_phase = RX_WAIT_HIGH;
         end
      end

      case (tx_phase)
         TX_START:  res.tx_line = 1'b0;
         TX_DATA:   res.tx_line = tx_shift[0];
         TX_PARITY: res.tx_line = tx_parity;
         default:   res.tx_line = 1'b1;
      endcase
      res.tx_busy  = tx_phase != TX_IDLE;
      res.rx_valid = got_word;
      res.rx_data  = got_word ? rx_word : '0;
      return res;
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t ns: %s", $time, what);
      mismatch_total++;
   endtask

   // follow the settings, queue one expected result per accepted item, compare
   always @(posedge clock) begin
      if (reset) begin
         cfg_period     = BIT_PERIOD_RST;
         cfg_dbits      = DATA_BITS_RST;
         cfg_parity     = PARITY_MODE_RST;
         cfg_stop       = STOP_BITS_RST;
         tx_phase       = TX_IDLE;
         tx_timer       = 0;
         tx_count       = '0;
         tx_shift       = '0;
         tx_parity      = 1'b0;
         rx_phase       = RX_WAIT_HIGH;
         rx_timer       = 0;
         rx_count       = '0;
         rx_shift       = '0;
         mismatch_total = 0;
         line_state_q.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_BIT_PERIOD:  cfg_period = csr_wdata[BIT_PERIOD_W-1:0];
               CSR_DATA_BITS:   cfg_dbits  = csr_wdata[DATA_BITS_W-1:0];
               CSR_PARITY_MODE: cfg_parity = csr_wdata[PARITY_MODE_W-1:0];
               CSR_STOP_BITS:   cfg_stop   = csr_wdata[STOP_BITS_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) line_state_q.push_back(uart_tick(req_item));
         if (rsp_valid && !rsp_stall) begin
            if (line_state_q.size() == 0) begin
               report_mismatch($sformatf("result item %h with no item pending", rsp_item));
            end else begin
               want = line_state_q.pop_front();
               if (rsp_item.tx_line !== want.tx_line)
                  report_mismatch($sformatf("tx_line expected %b got %b",
                                            want.tx_line, rsp_item.tx_line));
               if (rsp_item.tx_busy !== want.tx_busy)
                  report_mismatch($sformatf("tx_busy expected %b got %b",
                                            want.tx_busy, rsp_item.tx_busy));
               if (rsp_item.rx_valid !== want.rx_valid)
                  report_mismatch($sformatf("rx_valid expected %b got %b",
                                            want.rx_valid, rsp_item.rx_valid));
               if (rsp_item.rx_data !== want.rx_data)
                  report_mismatch($sformatf("rx_data expected %h got %h",
                                            want.rx_data, rsp_item.rx_data));
            end
         end
      end
      mismatch_count <= mismatch_total;
      pending_ticks  <= line_state_q.size();
   end

endmodule

// File: dv/tb_uart_transceiver_core.sv
// ----------------------------------------------------------------------------
// tb_uart_transceiver_core
// drives tick items into the uart transceiver core: transmit requests with
// random bytes and a receive line carrying whole frames, broken frames and
// noise, over a series of frame settings; the checker predicts and compares
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_uart_transceiver_core;
   import utx_pkg::*;

   localparam int                       TIMEOUT_CYCLES  = 200000;
   localparam int                       PHASES          = 10;
   localparam logic [PARITY_MODE_W-1:0] PARITY_RESERVED = 2'd3;
   // receive line for the directed items: arm, start, 8'ha5, even parity, stops
   localparam logic [19:0]              DIRECTED_RX     = 20'b1111_1111_1010_1001_0101;

   typedef struct {
      logic        level;
      int unsigned len;
   } line_run_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   req_item_type           req_item;
   logic                   rsp_valid;
   logic                   rsp_stall;
   rsp_item_type           rsp_item;
   logic                   csr_write;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   int                     mismatch_count;
   int                     pending_ticks;
   int unsigned            stall_tick;

   // frame settings per phase, extremes and out-of-range codes among them
   int unsigned              ph_period [PHASES] = '{4, 0, 1, 3, 7, 2, 65535, 5, 6, 20};
   int unsigned              ph_dbits  [PHASES] = '{8, 0, 15, 5, 7, 1, 8, 8, 4, 12};
   logic [PARITY_MODE_W-1:0] ph_parity [PHASES] = '{PARITY_NONE, PARITY_ODD, PARITY_RESERVED,
                                                    PARITY_EVEN, PARITY_ODD, PARITY_EVEN,
                                                    PARITY_ODD, PARITY_EVEN, PARITY_NONE,
                                                    PARITY_ODD};
   int unsigned              ph_stop   [PHASES] = '{1, 0, 3, 2, 1, 2, 2, 1, 2, 1};
   int unsigned              ph_items  [PHASES] = '{160, 120, 120, 160, 180, 120, 80, 200,
                                                    160, 250};

   // settings currently loaded, used to shape the receive line
   logic [BIT_PERIOD_W-1:0]  cur_period;
   logic [DATA_BITS_W-1:0]   cur_dbits;
   logic [PARITY_MODE_W-1:0] cur_parity;
   logic [STOP_BITS_W-1:0]   cur_stop;

   // receive line as runs of one level
   line_run_type rx_runs[$];
   int unsigned  rx_left;
   logic         rx_level;

   uart_transceiver_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   uart_frame_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_item       (req_item),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_item       (rsp_item),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending_ticks  (pending_ticks)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // receiver stalls: none, light, heavy, then long regular stretches
   always @(posedge clock) begin
      if (reset) begin
         stall_tick <= 0;
         rsp_stall  <= 1'b0;
      end else begin
         stall_tick <= stall_tick + 1;
         case (stall_tick[9:8])
            2'd0:    rsp_stall <= 1'b0;
            2'd1:    rsp_stall <= $urandom_range(0, 3) == 0;
            2'd2:    rsp_stall <= $urandom_range(0, 9) < 6;
            default: rsp_stall <= stall_tick[3:0] < 4'd7;
         endcase
      end
   end

   function automatic void add_noise(int unsigned runs);
      repeat (runs) rx_runs.push_back('{level: 1'($urandom), len: $urandom_range(1, 3)});
   endfunction

   // next stretch of receive traffic: idle, noise, whole or cut-off frame
   function automatic void plan_rx_traffic();
      int unsigned p;
      int unsigned nb;
      int unsigned ns;
      int unsigned kind;
      int unsigned cut;
      int unsigned blen;
      logic [7:0]  w;
      logic        pbit;
      logic        jitter;
      logic        levels[$];
      p    = (cur_period == 0) ? 1 : cur_period;
      nb   = (cur_dbits == 0) ? 1 : (cur_dbits > 8) ? 8 : cur_dbits;
      ns   = (cur_stop == 0) ? 1 : (cur_stop == 3) ? 2 : cur_stop;
      kind = $urandom_range(0, 9);
      // high first so the receiver arms
      rx_runs.push_back('{level: 1'b1, len: $urandom_range(1, (p > 8) ? 16 : 2 * p)});
      if (kind == 6 || kind == 7) return;
      if (kind == 8) begin
         add_noise($urandom_range(1, 12));
         return;
      end
      w    = BYTE_W'($urandom_range(0, 255));
      pbit = cur_parity == PARITY_ODD;
      levels.push_back(1'b0);
      for (int i = 0; i < nb; i++) begin
         levels.push_back(w[i]);
         pbit ^= w[i];
      end
      // parity now and then wrong, the receiver ignores it
      if (cur_parity == PARITY_EVEN || cur_parity == PARITY_ODD)
         levels.push_back(pbit ^ ($urandom_range(0, 7) == 0));
      repeat (ns) levels.push_back(1'b1);
      cut    = (kind == 9) ? $urandom_range(1, levels.size() - 1) : levels.size();
      jitter = (p >= 4) && ($urandom_range(0, 3) == 0);
      for (int i = 0; i < cut; i++) begin
         blen = jitter ? p - 1 + $urandom_range(0, 2) : p;
         rx_runs.push_back('{level: levels[i], len: blen});
      end
      if (kind == 9) add_noise($urandom_range(1, 6));
   endfunction

   function automatic logic next_rx_pin();
      line_run_type run;
      if (rx_left == 0) begin
         if (rx_runs.size() == 0) plan_rx_traffic();
         run      = rx_runs.pop_front();
         rx_level = run.level;
         rx_left  = run.len;
      end
      rx_left--;
      return rx_level;
   endfunction

   // offer one tick item and hold it until taken
   task automatic push_tick(input req_item_type it);
      req_valid <= 1'b1;
      req_item  <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // stop sending and wait until every result item is back
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_ticks != 0) @(posedge clock);
   endtask

   task automatic load_frame_cfg(input int unsigned period, input int unsigned dbits,
                                 input logic [PARITY_MODE_W-1:0] parity,
                                 input int unsigned stop);
      cur_period = BIT_PERIOD_W'(period);
      cur_dbits  = DATA_BITS_W'(dbits);
      cur_parity = parity;
      cur_stop   = STOP_BITS_W'(stop);
      csr_write <= 1'b1;
      csr_index <= CSR_BIT_PERIOD;
      csr_wdata <= CSR_DATA_W'(period);
      @(posedge clock);
      csr_index <= CSR_DATA_BITS;
      csr_wdata <= CSR_DATA_W'(dbits);
      @(posedge clock);
      csr_index <= CSR_PARITY_MODE;
      csr_wdata <= CSR_DATA_W'(parity);
      @(posedge clock);
      csr_index <= CSR_STOP_BITS;
      csr_wdata <= CSR_DATA_W'(stop);
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   initial begin : stimulus
      req_item_type tick_in;
      int unsigned  burst_left;
      int unsigned  gap;
      logic         steady;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_item  <= '0;
      csr_write <= 1'b0;
      csr_index <= CSR_BIT_PERIOD;
      csr_wdata <= '0;
      rx_left    = 0;
      rx_level   = 1'b1;
      cur_period = BIT_PERIOD_RST;
      cur_dbits  = DATA_BITS_RST;
      cur_parity = PARITY_MODE_RST;
      cur_stop   = STOP_BITS_RST;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset settings, field extremes, request while busy
      push_tick('{tx_start: 1'b1, tx_data: 8'hFF, rx_pin: 1'b1});
      push_tick('{tx_start: 1'b0, tx_data: 8'h00, rx_pin: 1'b0});
      push_tick('{tx_start: 1'b1, tx_data: 8'h00, rx_pin: 1'b1});
      push_tick('{tx_start: 1'b0, tx_data: 8'hFF, rx_pin: 1'b0});
      drain_results();

      // zero bit period, even parity, two stops: one frame, then requests while it is busy
      load_frame_cfg(0, 8, PARITY_EVEN, 2);
      for (int k = 0; k < 20; k++) begin
         tick_in.tx_start = (k == 0) || (k == 5) || (k == 12);
         tick_in.tx_data  = (k == 0) ? 8'hFF : (k == 5) ? 8'h3C : 8'h00;
         tick_in.rx_pin   = DIRECTED_RX[k];
         push_tick(tick_in);
      end
      drain_results();

      // random traffic per settings phase, sender in bursts
      for (int ph = 0; ph < PHASES; ph++) begin
         load_frame_cfg(ph_period[ph], ph_dbits[ph], ph_parity[ph], ph_stop[ph]);
         rx_runs.delete();
         rx_left    = 0;
         steady     = $urandom_range(0, 2) == 0;
         burst_left = 0;
         for (int n = 0; n < ph_items[ph]; n++) begin
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 40);
               gap        = steady ? 0 : $urandom_range(0, 6);
               if (gap != 0) begin
                  req_valid <= 1'b0;
                  repeat (gap) @(posedge clock);
               end
            end
            burst_left--;
            tick_in.tx_start = $urandom_range(0, 5) == 0;
            tick_in.tx_data  = BYTE_W'($urandom_range(0, 255));
            tick_in.rx_pin   = next_rx_pin();
            push_tick(tick_in);
         end
         drain_results();
      end

      repeat (4) @(posedge clock);
      if (mismatch_count == 0 && pending_ticks == 0) begin
         $display("uart_transceiver_core test passed");
      end else begin
         $display("uart_transceiver_core test failed");
      end
      $finish;
   end

   // hang guard
   initial begin
      repeat (TIMEOUT_CYCLES) @(posedge clock);
      $display("uart_transceiver_core test failed");
      $finish;
   end

endmodule
